@@ design/bdhr_pkg.sv @@
// shared types and constants for the button debounce, hold and repeat block
package bdhr_pkg;

    typedef enum logic [1:0] {
        OP_SAMPLE      = 2'd0,
        OP_TAKE_PRESS  = 2'd1,
        OP_TAKE_REPEAT = 2'd2,
        OP_CLEAR       = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        CFG_DEBOUNCE = 3'd0,
        CFG_HOLD     = 3'd1,
        CFG_INITIAL  = 3'd2,
        CFG_SLOW     = 3'd3,
        CFG_FAST     = 3'd4
    } t_cfg_index;

    localparam logic [1:0] STAGE_INITIAL = 2'd0;
    localparam logic [1:0] STAGE_SLOW    = 2'd1;
    localparam logic [1:0] STAGE_FAST    = 2'd2;

    localparam logic [2:0] REPEAT_SLOW_AT = 3'd3;
    localparam logic [2:0] REPEAT_FAST_AT = 3'd5;

    localparam logic [15:0] DEBOUNCE_RESET = 16'd50;
    localparam logic [15:0] HOLD_RESET     = 16'd800;
    localparam logic [15:0] INITIAL_RESET  = 16'd400;
    localparam logic [15:0] SLOW_RESET     = 16'd200;
    localparam logic [15:0] FAST_RESET     = 16'd80;

    typedef struct packed {
        logic [15:0] debounce_ms;
        logic [15:0] hold_ms;
        logic [15:0] initial_interval_ms;
        logic [15:0] slow_interval_ms;
        logic [15:0] fast_interval_ms;
    } t_cfg;

    typedef struct packed {
        logic        previous_raw;
        logic        debounced;
        logic [31:0] change_stamp;
        logic [31:0] press_stamp;
        logic [31:0] action_stamp;
        logic        pending_flag;
        logic        hold_flag;
        logic [2:0]  repeat_count;
        logic [1:0]  interval_stage;
    } t_state;

    typedef struct packed {
        logic granted;
        logic stable_level;
        logic holding;
        logic event_pending;
    } t_result;

    localparam t_state STATE_RESET = '{
        previous_raw:   1'b1,
        debounced:      1'b1,
        change_stamp:   32'd0,
        press_stamp:    32'd0,
        action_stamp:   32'd0,
        pending_flag:   1'b0,
        hold_flag:      1'b0,
        repeat_count:   3'd0,
        interval_stage: STAGE_INITIAL
    };

endpackage

@@ design/bdhr_step.sv @@
// next-state and result logic for one request
module bdhr_step
    import bdhr_pkg::*;
(
    input  t_cfg        i_cfg,
    input  t_state      i_state,
    input  t_opcode     i_opcode,
    input  logic        i_raw_level,
    input  logic [31:0] i_now_ms,
    output t_state      o_state,
    output t_result     o_result
);

    always_comb begin
        t_state      n_st;
        logic        granted;
        logic [15:0] interval;

        n_st     = i_state;
        granted  = 1'b0;
        interval = i_cfg.initial_interval_ms;

        unique case (i_opcode)
            OP_SAMPLE: begin
                if (i_raw_level != i_state.previous_raw) begin
                    n_st.change_stamp = i_now_ms;
                end
                if ((i_now_ms - n_st.change_stamp) >= {16'd0, i_cfg.debounce_ms}
                        && i_raw_level != n_st.debounced) begin
                    n_st.debounced = i_raw_level;
                    if (!i_raw_level) begin
                        n_st.press_stamp    = i_now_ms;
                        n_st.action_stamp   = i_now_ms;
                        n_st.pending_flag   = 1'b1;
                        n_st.repeat_count   = 3'd0;
                        n_st.interval_stage = STAGE_INITIAL;
                        n_st.hold_flag      = 1'b0;
                    end else begin
                        n_st.hold_flag = 1'b0;
                    end
                end
                if (!n_st.debounced && !n_st.hold_flag
                        && (i_now_ms - n_st.press_stamp) >= {16'd0, i_cfg.hold_ms}) begin
                    n_st.hold_flag    = 1'b1;
                    n_st.action_stamp = i_now_ms;
                end
                priority if (n_st.interval_stage == STAGE_INITIAL) begin
                    interval = i_cfg.initial_interval_ms;
                end else if (n_st.interval_stage == STAGE_SLOW) begin
                    interval = i_cfg.slow_interval_ms;
                end else begin
                    interval = i_cfg.fast_interval_ms;
                end
                if (!n_st.debounced && n_st.hold_flag
                        && (i_now_ms - n_st.action_stamp) >= {16'd0, interval}) begin
                    n_st.action_stamp = i_now_ms;
                    if (n_st.repeat_count < REPEAT_FAST_AT) begin
                        n_st.repeat_count = n_st.repeat_count + 3'd1;
                    end
                    if (n_st.repeat_count >= REPEAT_FAST_AT) begin
                        n_st.interval_stage = STAGE_FAST;
                    end else if (n_st.repeat_count >= REPEAT_SLOW_AT) begin
                        n_st.interval_stage = STAGE_SLOW;
                    end
                    n_st.pending_flag = 1'b1;
                end
                n_st.previous_raw = i_raw_level;
            end
            OP_TAKE_PRESS: begin
                if (i_state.pending_flag) begin
                    n_st.pending_flag = 1'b0;
                    granted           = 1'b1;
                end
            end
            OP_TAKE_REPEAT: begin
                if (i_state.hold_flag && i_state.pending_flag) begin
                    n_st.pending_flag = 1'b0;
                    granted           = 1'b1;
                end
            end
            OP_CLEAR: begin
                n_st.repeat_count   = 3'd0;
                n_st.interval_stage = STAGE_INITIAL;
                n_st.hold_flag      = 1'b0;
                n_st.pending_flag   = 1'b0;
            end
            default: begin
                n_st = i_state;
            end
        endcase

        o_state                = n_st;
        o_result.granted       = granted;
        o_result.stable_level  = n_st.debounced;
        o_result.holding       = n_st.hold_flag;
        o_result.event_pending = n_st.pending_flag;
    end

endmodule

@@ design/button_debounce_hold_repeat.sv @@
// top level: active-low push-button debounce with hold detection and auto-repeat
// Each request is a sample (raw level and millisecond stamp), a take of a pending press or
// repeat, or a clear of the repeat state, and gives one result. The request is held in the
// input register from its accepting edge, and its result is loaded into the result register
// when that register is empty or its result is being taken downstream. One request is taken
// every cycle while the output is not stalled: the button state is updated in a loop of
// subtract-and-compare logic, and the result register lets a new request enter while the
// last result still waits downstream. Configuration writes are taken at once and act on the
// request then in the input register, so they belong in gaps with no request in flight.
module button_debounce_hold_repeat
    import bdhr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // raw_level, now_ms, zero fill
    input  logic [1:0]  s_axis_tuser,  // opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // granted, stable_level, holding, event_pending, zero fill
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_cfg        r_cfg;
    t_state      r_state;
    t_state      n_state;
    t_result     n_result;
    logic        r_in_valid;
    t_opcode     r_opcode;
    logic        r_raw;
    logic [31:0] r_now;
    logic        r_out_valid;
    t_result     r_result;
    logic        advance;

    assign o_cfg_ready   = 1'b1;
    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_result.event_pending, r_result.holding,
                            r_result.stable_level, r_result.granted};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms         <= DEBOUNCE_RESET;
            r_cfg.hold_ms             <= HOLD_RESET;
            r_cfg.initial_interval_ms <= INITIAL_RESET;
            r_cfg.slow_interval_ms    <= SLOW_RESET;
            r_cfg.fast_interval_ms    <= FAST_RESET;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_DEBOUNCE: r_cfg.debounce_ms         <= i_cfg_data;
                CFG_HOLD:     r_cfg.hold_ms             <= i_cfg_data;
                CFG_INITIAL:  r_cfg.initial_interval_ms <= i_cfg_data;
                CFG_SLOW:     r_cfg.slow_interval_ms    <= i_cfg_data;
                CFG_FAST:     r_cfg.fast_interval_ms    <= i_cfg_data;
                default:      r_cfg                     <= r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_opcode <= t_opcode'(s_axis_tuser);
            r_raw    <= s_axis_tdata[0];
            r_now    <= s_axis_tdata[32:1];
        end
    end

    bdhr_step u_step (
        .i_cfg       (r_cfg),
        .i_state     (r_state),
        .i_opcode    (r_opcode),
        .i_raw_level (r_raw),
        .i_now_ms    (r_now),
        .o_state     (n_state),
        .o_result    (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= STATE_RESET;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_result <= n_result;
        end
    end

endmodule

@@ design/bdhr_checker.sv @@
// port-level checks for the button debounce, hold and repeat block
module bdhr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // a grant clears the pending flag
    a_grant_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> !m_axis_tdata[3])
        else $error("pending flag still set after a grant");

    // holding only while the debounced level is pressed
    a_hold_pressed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[2] |-> !m_axis_tdata[1])
        else $error("holding while released");

endmodule

bind button_debounce_hold_repeat bdhr_checker u_bdhr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
